/* src/hcb_pkg.sv */
// shared types and constants for the huffman code builder
// no dependencies; imported by hcb_ctrl, hcb_datapath and huffman_code_builder
package hcb_pkg;

    // default leaf capacity
    localparam int HCB_MAX_LEAVES = 32;

    // field widths
    localparam int IN_WEIGHT_W  = 16;
    localparam int WEIGHT_W     = 21;
    localparam int LEAF_IDX_W   = 5;
    localparam int CODE_W       = 31;
    localparam int CODE_LEN_W   = 5;

    // stream data widths
    localparam int S_TDATA_W    = 16;
    localparam int OUT_FIELDS_W = LEAF_IDX_W + CODE_W + CODE_LEN_W;
    localparam int M_TDATA_W    = 48;
    localparam int M_PAD_W      = M_TDATA_W - OUT_FIELDS_W;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic build_init;
        logic scan_init;
        logic scan_step;
        logic merge_w;
        logic merge_p;
        logic trace_first;
        logic trace_next;
        logic trace_par;
        logic trace_upd;
        logic emit;
        logic finish;
    } hcb_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic build_done;
        logic scan_last;
        logic node_linked;
        logic leaf_last;
        logic out_taken;
    } hcb_stat_t;

endpackage

/* src/hcb_ctrl.sv */
// sequencing state machine for load, tree build, code trace and output
// depends on hcb_pkg for the command and status structs
module hcb_ctrl
    import hcb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_tvalid,
    input  logic      s_tlast,
    output logic      s_tready,
    input  hcb_stat_t stat,
    output hcb_cmd_t  cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_BINIT = 4'd1;
    localparam logic [3:0] S_BCHK  = 4'd2;
    localparam logic [3:0] S_SCAN  = 4'd3;
    localparam logic [3:0] S_SWAIT = 4'd4;
    localparam logic [3:0] S_MRGW  = 4'd5;
    localparam logic [3:0] S_MRGP  = 4'd6;
    localparam logic [3:0] S_TCHK  = 4'd7;
    localparam logic [3:0] S_TPAR  = 4'd8;
    localparam logic [3:0] S_TUPD  = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        cmd        = '0;
        s_tready   = 1'b0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load = 1'b1;
                    if (s_tlast)
                    begin
                        state_next = S_BINIT;
                    end
                end
            end
            S_BINIT:
            begin
                cmd.build_init = 1'b1;
                state_next     = S_BCHK;
            end
            S_BCHK:
            begin
                if (stat.build_done)
                begin
                    cmd.trace_first = 1'b1;
                    state_next      = S_TCHK;
                end
                else
                begin
                    cmd.scan_init = 1'b1;
                    state_next    = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = S_SWAIT;
                end
            end
            S_SWAIT:
            begin
                state_next = S_MRGW;
            end
            S_MRGW:
            begin
                cmd.merge_w = 1'b1;
                state_next  = S_MRGP;
            end
            S_MRGP:
            begin
                cmd.merge_p = 1'b1;
                state_next  = S_BCHK;
            end
            S_TCHK:
            begin
                if (stat.node_linked)
                begin
                    state_next = S_TPAR;
                end
                else
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_OUT;
                end
            end
            S_TPAR:
            begin
                cmd.trace_par = 1'b1;
                state_next    = S_TUPD;
            end
            S_TUPD:
            begin
                cmd.trace_upd = 1'b1;
                state_next    = S_TCHK;
            end
            S_OUT:
            begin
                if (stat.out_taken)
                begin
                    if (stat.leaf_last)
                    begin
                        cmd.finish = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.trace_next = 1'b1;
                        state_next     = S_TCHK;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* src/hcb_datapath.sv */
// node memories, two-minimum scan, merge write and code trace registers
// depends on hcb_pkg for widths and the command and status structs
module hcb_datapath
    import hcb_pkg::*;
#(
    parameter int MAX_LEAVES = HCB_MAX_LEAVES
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  hcb_cmd_t               cmd,
    output hcb_stat_t              stat,
    input  logic [IN_WEIGHT_W-1:0] weight,
    input  logic                   out_ready,
    output logic                   out_valid,
    output logic [LEAF_IDX_W-1:0]  out_leaf_index,
    output logic [CODE_W-1:0]      out_code_bits,
    output logic [CODE_LEN_W-1:0]  out_code_length,
    output logic                   out_last
);

    localparam int NODE_CNT   = 2 * MAX_LEAVES - 1;
    localparam int NODE_W     = $clog2(2 * MAX_LEAVES);
    localparam int CNT_W      = $clog2(MAX_LEAVES + 1);
    localparam int DEPTH_W    = (NODE_W > CODE_LEN_W) ? NODE_W : CODE_LEN_W;
    localparam int LEAF_EXT_W = (CNT_W > LEAF_IDX_W) ? CNT_W : LEAF_IDX_W;

    // node stores
    logic [WEIGHT_W-1:0] weight_mem [NODE_CNT];
    logic [NODE_W-1:0]   parent_mem [NODE_CNT];
    logic [NODE_W-1:0]   left_mem   [NODE_CNT];
    logic [NODE_CNT-1:0] linked_reg;

    logic [WEIGHT_W-1:0] wrd_reg;
    logic [NODE_W-1:0]   prd_reg;
    logic [NODE_W-1:0]   lrd_reg;

    // control and work registers
    logic [CNT_W-1:0]    cnt_reg;
    logic [NODE_W-1:0]   k_reg;
    logic [NODE_W-1:0]   i_reg;
    logic                pv_reg;
    logic [NODE_W-1:0]   pidx_reg;
    logic [NODE_W-1:0]   a_reg;
    logic [NODE_W-1:0]   b_reg;
    logic [WEIGHT_W-1:0] w1_reg;
    logic [WEIGHT_W-1:0] w2_reg;
    logic                f1_reg;
    logic                f2_reg;
    logic [CNT_W-1:0]    leaf_reg;
    logic [NODE_W-1:0]   c_reg;
    logic [NODE_W-1:0]   f_reg;
    logic [DEPTH_W-1:0]  len_reg;
    logic [CODE_W-1:0]   code_reg;
    logic                out_valid_reg;
    logic [LEAF_IDX_W-1:0] out_leaf_reg;
    logic [CODE_W-1:0]   out_code_reg;
    logic [CODE_LEN_W-1:0] out_len_reg;
    logic                out_last_reg;

    logic                room;
    logic [NODE_W-1:0]   n_node;
    logic [NODE_W-1:0]   total_node;
    logic [CNT_W-1:0]    leaf_inc;
    logic [LEAF_EXT_W-1:0] leaf_ext;
    logic                cand;
    logic                wmem_we;
    logic [NODE_W-1:0]   wmem_addr;
    logic [WEIGHT_W-1:0] wmem_data;
    logic                pmem_we;
    logic [NODE_W-1:0]   pmem_addr;

    // derived values
    assign room       = cnt_reg != CNT_W'(MAX_LEAVES);
    assign n_node     = NODE_W'(cnt_reg);
    assign total_node = n_node + n_node - NODE_W'(1);
    assign leaf_inc   = leaf_reg + CNT_W'(1);
    assign leaf_ext   = LEAF_EXT_W'(leaf_reg);
    assign cand       = pv_reg && !linked_reg[pidx_reg];

    // status to the controller
    assign stat.build_done  = k_reg == total_node;
    assign stat.scan_last   = i_reg == (k_reg - NODE_W'(1));
    assign stat.node_linked = linked_reg[c_reg];
    assign stat.leaf_last   = leaf_reg == (cnt_reg - CNT_W'(1));
    assign stat.out_taken   = out_valid_reg && out_ready;

    // memory write port selection
    assign wmem_we   = (cmd.load && room) || cmd.merge_w;
    assign wmem_addr = cmd.merge_w ? k_reg : n_node;
    assign wmem_data = cmd.merge_w ? (w1_reg + w2_reg) : WEIGHT_W'(weight);
    assign pmem_we   = cmd.merge_w || cmd.merge_p;
    assign pmem_addr = cmd.merge_w ? a_reg : b_reg;

    // weight store: scan reads at the scan index
    always_ff @(posedge clk)
    begin
        if (wmem_we)
        begin
            weight_mem[wmem_addr] <= wmem_data;
        end
        wrd_reg <= weight_mem[i_reg];
    end

    // parent store: trace reads at the current node
    always_ff @(posedge clk)
    begin
        if (pmem_we)
        begin
            parent_mem[pmem_addr] <= k_reg;
        end
        prd_reg <= parent_mem[c_reg];
    end

    // left child store: trace reads at the parent just fetched
    always_ff @(posedge clk)
    begin
        if (cmd.merge_w)
        begin
            left_mem[k_reg] <= a_reg;
        end
        lrd_reg <= left_mem[prd_reg];
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            pv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.finish)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.load && room)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            pv_reg <= cmd.scan_step;
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (stat.out_taken)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // parent marks
    always_ff @(posedge clk)
    begin
        if (cmd.load && room)
        begin
            linked_reg[n_node] <= 1'b0;
        end
        if (cmd.merge_w)
        begin
            linked_reg[a_reg] <= 1'b1;
            linked_reg[b_reg] <= 1'b1;
            linked_reg[k_reg] <= 1'b0;
        end
    end

    // build: merge counter and two-minimum scan
    always_ff @(posedge clk)
    begin
        if (cmd.build_init)
        begin
            k_reg <= n_node;
        end
        else if (cmd.merge_p)
        begin
            k_reg <= k_reg + NODE_W'(1);
        end
        pidx_reg <= i_reg;
        if (cmd.scan_init)
        begin
            i_reg  <= '0;
            f1_reg <= 1'b0;
            f2_reg <= 1'b0;
        end
        else
        begin
            if (cmd.scan_step)
            begin
                i_reg <= i_reg + NODE_W'(1);
            end
            // strict compare keeps the lower index on ties
            if (cand)
            begin
                if (!f1_reg || (wrd_reg < w1_reg))
                begin
                    b_reg  <= a_reg;
                    w2_reg <= w1_reg;
                    f2_reg <= f1_reg;
                    a_reg  <= pidx_reg;
                    w1_reg <= wrd_reg;
                    f1_reg <= 1'b1;
                end
                else if (!f2_reg || (wrd_reg < w2_reg))
                begin
                    b_reg  <= pidx_reg;
                    w2_reg <= wrd_reg;
                    f2_reg <= 1'b1;
                end
            end
        end
    end

    // code trace from leaf toward the root
    always_ff @(posedge clk)
    begin
        if (cmd.trace_first)
        begin
            leaf_reg <= '0;
            c_reg    <= '0;
            len_reg  <= '0;
            code_reg <= '0;
        end
        else if (cmd.trace_next)
        begin
            leaf_reg <= leaf_inc;
            c_reg    <= NODE_W'(leaf_inc);
            len_reg  <= '0;
            code_reg <= '0;
        end
        else if (cmd.trace_par)
        begin
            f_reg <= prd_reg;
        end
        else if (cmd.trace_upd)
        begin
            // right branch gives a one; bits past the field width are dropped
            if ((lrd_reg != c_reg) && (len_reg < DEPTH_W'(CODE_W)))
            begin
                code_reg[len_reg[CODE_LEN_W-1:0]] <= 1'b1;
            end
            len_reg <= len_reg + DEPTH_W'(1);
            c_reg   <= f_reg;
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_leaf_reg <= leaf_ext[LEAF_IDX_W-1:0];
            out_code_reg <= code_reg;
            out_len_reg  <= len_reg[CODE_LEN_W-1:0];
            out_last_reg <= stat.leaf_last;
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_leaf_index  = out_leaf_reg;
    assign out_code_bits   = out_code_reg;
    assign out_code_length = out_len_reg;
    assign out_last        = out_last_reg;

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_LEAVES))
        else $error("leaf count above capacity");

    a_merge_pair: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.merge_w |-> (f1_reg && f2_reg && (a_reg != b_reg)))
        else $error("merge without two distinct parentless nodes");

    a_merge_order: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.merge_w |-> ((a_reg < k_reg) && (b_reg < k_reg)))
        else $error("merged child not below the new node");

    a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !cmd.load)
        else $error("item loaded while a code is pending");
`endif

endmodule

/* src/huffman_code_builder.sv */
// huffman code builder: one weight per cycle while loading, then build and trace
// build for n leaves: each merge k scans over k nodes, then writes the new node and its parent links
// trace: each code bit takes a check, a parent fetch and an update step; one code item per leaf in load order
// output waits for m_tready; no new weight is taken from the last item until the last code
// rst_n is asynchronous active low: clears the leaf count and control; node stores are not cleared
module huffman_code_builder
    import hcb_pkg::*;
#(
    parameter int MAX_LEAVES = HCB_MAX_LEAVES
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // [15:0] weight
    input  logic                 s_tlast,  // last_weight
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,  // [4:0] leaf_index, [35:5] code_bits,
                                           // [40:36] code_length, [47:41] zero
    output logic                 m_tlast   // last_code
);

    hcb_cmd_t              cmd;
    hcb_stat_t             stat;
    logic [LEAF_IDX_W-1:0] leaf_index;
    logic [CODE_W-1:0]     code_bits;
    logic [CODE_LEN_W-1:0] code_length;

    // sequencer
    hcb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // node stores and arithmetic
    hcb_datapath #(
        .MAX_LEAVES (MAX_LEAVES)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .weight          (s_tdata[IN_WEIGHT_W-1:0]),
        .out_ready       (m_tready),
        .out_valid       (m_tvalid),
        .out_leaf_index  (leaf_index),
        .out_code_bits   (code_bits),
        .out_code_length (code_length),
        .out_last        (m_tlast)
    );

    // pack the result item
    assign m_tdata = {{M_PAD_W{1'b0}}, code_length, code_bits, leaf_index};

endmodule

/* sim/tb_top.sv */
// self-checking testbench for huffman_code_builder: directed weight table, then random batches
// depends on src/hcb_pkg.sv and the huffman_code_builder rtl; codes are checked by a local tree builder
module tb_top;
    import hcb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEMS       = 470;
    localparam int CALM_TAIL   = 50;
    localparam int LONG_HOLD   = 2500;
    localparam int STALL_LIMIT = 20000;
    localparam int NODE_SLOTS  = 2 * HCB_MAX_LEAVES;

    // one code item as the block emits it
    typedef struct packed {
        logic [LEAF_IDX_W-1:0] leaf;
        logic [CODE_W-1:0]     bits;
        logic [CODE_LEN_W-1:0] len;
        logic                  lst;
    } code_item_t;

    // directed row: weight, last flag, and up to two hand-worked codes
    typedef struct {
        logic [IN_WEIGHT_W-1:0] w;
        bit                     lst;
        int                     ntyped;
        logic [CODE_W-1:0]      c0;
        logic [CODE_LEN_W-1:0]  l0;
        logic [CODE_W-1:0]      c1;
        logic [CODE_LEN_W-1:0]  l1;
    } weight_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 s_tlast;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;

    // directed weights; rows with ntyped > 0 carry their codes, the rest use the tree builder
    weight_row_t weight_rows[19] = '{
        '{16'hFFFF, 1'b1, 1, 31'd0, 5'd0, 31'd0, 5'd0},  // single leaf
        '{16'd5,    1'b0, 0, 31'd0, 5'd0, 31'd0, 5'd0},
        '{16'd3,    1'b1, 2, 31'd1, 5'd1, 31'd0, 5'd1},  // lighter second leaf goes left
        '{16'd7,    1'b0, 0, 31'd0, 5'd0, 31'd0, 5'd0},
        '{16'd7,    1'b1, 2, 31'd0, 5'd1, 31'd1, 5'd1},  // tie goes to lower index
        '{16'h0000, 1'b0, 0, 31'd0, 5'd0, 31'd0, 5'd0},
        '{16'hFFFF, 1'b1, 2, 31'd0, 5'd1, 31'd1, 5'd1},  // weight extremes
        '{16'd0,    1'b0, 0, 31'd0, 5'd0, 31'd0, 5'd0},  // all-zero ties
        '{16'd0,    1'b0, 0, 31'd0, 5'd0, 31'd0, 5'd0},
        '{16'd0,    1'b1, 0, 31'd0, 5'd0, 31'd0, 5'd0},
        '{16'd1,    1'b0, 0, 31'd0, 5'd0, 31'd0, 5'd0},  // skewed weights, deep codes
        '{16'd1,    1'b0, 0, 31'd0, 5'd0, 31'd0, 5'd0},
        '{16'd2,    1'b0, 0, 31'd0, 5'd0, 31'd0, 5'd0},
        '{16'd3,    1'b0, 0, 31'd0, 5'd0, 31'd0, 5'd0},
        '{16'd5,    1'b0, 0, 31'd0, 5'd0, 31'd0, 5'd0},
        '{16'd8,    1'b0, 0, 31'd0, 5'd0, 31'd0, 5'd0},
        '{16'd13,   1'b1, 0, 31'd0, 5'd0, 31'd0, 5'd0},
        '{16'hAAAA, 1'b0, 0, 31'd0, 5'd0, 31'd0, 5'd0},
        '{16'h5555, 1'b1, 0, 31'd0, 5'd0, 31'd0, 5'd0}
    };

    // local tree state
    logic [WEIGHT_W-1:0] node_wt[NODE_SLOTS];
    int                  node_up[NODE_SLOTS];
    int                  node_lft[NODE_SLOTS];
    bit                  node_joined[NODE_SLOTS];
    int                  leaves_held;

    code_item_t built_codes[$];
    code_item_t pending_codes[$];
    code_item_t want;

    int  items_sent;
    int  batches;
    int  weights_dropped;
    int  codes_checked;
    int  mismatches;
    int  stalled_cycles;
    bit  quiet;
    bit  calm;
    bit  hold_req;

    huffman_code_builder DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // least-weight node without a parent among 0..count-1, lower index wins ties
    function automatic int least_free(int count, int skip);
        int best = 0;
        bit found = 1'b0;
        for (int i = 0; i < count; i++)
        begin
            if (!node_joined[i] && i != skip && (!found || node_wt[i] < node_wt[best]))
            begin
                best = i;
                found = 1'b1;
            end
        end
        return best;
    endfunction

    // load one weight; on the last item build the tree and trace every leaf code
    function automatic void take_weight(logic [IN_WEIGHT_W-1:0] w, bit lst);
        int a;
        int b;
        int c;
        int len;
        int n;
        code_item_t r;
        built_codes.delete();
        if (leaves_held < HCB_MAX_LEAVES)
        begin
            node_wt[leaves_held] = WEIGHT_W'(w);
            node_joined[leaves_held] = 1'b0;
            leaves_held++;
        end
        else
            weights_dropped++;
        if (!lst)
            return;
        n = leaves_held;
        // merge the two lightest free nodes, lighter one on the left
        for (int k = n; k < 2 * n - 1; k++)
        begin
            a = least_free(k, -1);
            b = least_free(k, a);
            node_joined[a] = 1'b1;
            node_joined[b] = 1'b1;
            node_up[a] = k;
            node_up[b] = k;
            node_lft[k] = a;
            node_joined[k] = 1'b0;
            node_wt[k] = node_wt[a] + node_wt[b];
        end
        // walk each leaf up to the root, right branches give a 1
        for (int leaf = 0; leaf < n; leaf++)
        begin
            r = '0;
            c = leaf;
            len = 0;
            while (node_joined[c])
            begin
                if (node_lft[node_up[c]] != c && len < CODE_W)
                    r.bits[len] = 1'b1;
                len++;
                c = node_up[c];
            end
            r.leaf = leaf[LEAF_IDX_W-1:0];
            r.len = len[CODE_LEN_W-1:0];
            r.lst = (leaf == n - 1);
            built_codes.push_back(r);
        end
        leaves_held = 0;
    endfunction

    // random weight by batch style
    function automatic logic [IN_WEIGHT_W-1:0] pick_weight(int style, int pos);
        case (style)
            0:       return IN_WEIGHT_W'($urandom_range(0, 65535));
            1:       return IN_WEIGHT_W'($urandom_range(0, 7));
            2:       return (pos < IN_WEIGHT_W) ? IN_WEIGHT_W'(1 << pos) : 16'hFFFF;
            default: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        endcase
    endfunction

    // offer one weight item and wait for it to be taken
    task automatic offer(logic [IN_WEIGHT_W-1:0] w, bit lst, int row);
        code_item_t r;
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        s_tlast  <= lst;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items_sent++;
        if (lst)
            batches++;
        take_weight(w, lst);
        if (row >= 0 && weight_rows[row].ntyped > 0)
        begin
            for (int i = 0; i < weight_rows[row].ntyped; i++)
            begin
                r.leaf = i[LEAF_IDX_W-1:0];
                r.bits = (i == 0) ? weight_rows[row].c0 : weight_rows[row].c1;
                r.len  = (i == 0) ? weight_rows[row].l0 : weight_rows[row].l1;
                r.lst  = (i == weight_rows[row].ntyped - 1);
                pending_codes.push_back(r);
            end
        end
        else
        begin
            foreach (built_codes[i])
                pending_codes.push_back(built_codes[i]);
        end
    endtask

    // random sender gap
    task automatic sender_gap();
        if (!quiet && !calm && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
    endtask

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
            mismatches++;
        end
    endtask

    // code item checker and stall watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (pending_codes.size() == 0)
                begin
                    $display("%0t ns: unexpected code item, actual %0h", $time, m_tdata);
                    mismatches++;
                end
                else
                begin
                    want = pending_codes.pop_front();
                    check_field("leaf_index", 32'(want.leaf),
                                32'(m_tdata[LEAF_IDX_W-1:0]));
                    check_field("code_bits", 32'(want.bits),
                                32'(m_tdata[LEAF_IDX_W +: CODE_W]));
                    check_field("code_length", 32'(want.len),
                                32'(m_tdata[LEAF_IDX_W+CODE_W +: CODE_LEN_W]));
                    check_field("last_code", 32'(want.lst), 32'(m_tlast));
                    check_field("pad", 32'd0, 32'(m_tdata[M_TDATA_W-1 -: M_PAD_W]));
                    codes_checked++;
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stalled_cycles = 0;
            else
                stalled_cycles++;
            if (stalled_cycles >= STALL_LIMIT)
            begin
                $display("%0t ns: no handshake for %0d cycles", $time, STALL_LIMIT);
                $display("FAILURE");
                $finish;
            end
        end
    end

    // receiver: ready bursts, random stalls, one long hold-off on request
    initial
    begin
        m_tready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_req = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 3) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
    end

    // reset, directed table, random batches, drain
    initial
    begin
        int size;
        int style;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        leaves_held = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed weights
        foreach (weight_rows[r])
        begin
            sender_gap();
            offer(weight_rows[r].w, weight_rows[r].lst, r);
        end

        // random batches; the first and third exceed the leaf capacity, the second fills it exactly
        for (int bn = 0; items_sent < ITEMS; bn++)
        begin
            case ($urandom_range(0, 19))
                0:            size = $urandom_range(33, 40);
                1, 2:         size = $urandom_range(21, 32);
                3, 4, 5, 6, 7: size = $urandom_range(7, 20);
                default:      size = $urandom_range(1, 6);
            endcase
            if (bn == 0)
                size = 36;
            else if (bn == 1)
                size = HCB_MAX_LEAVES;
            else if (bn == 2)
                size = HCB_MAX_LEAVES + 1;
            else if (bn == 4)
                size = 20;
            style = $urandom_range(0, 5);
            if (style > 3)
                style = 0;
            calm = ($urandom_range(0, 9) < 3);
            // long receiver hold-off while a batch of 20 weights keeps coming
            if (bn == 4)
                hold_req = 1'b1;
            // before batch 8, let every code drain
            if (bn == 8 && pending_codes.size() != 0)
            begin
                s_tvalid <= 1'b0;
                while (pending_codes.size() != 0)
                    @(posedge clk);
            end
            for (int i = 0; i < size; i++)
            begin
                if (items_sent >= ITEMS - CALM_TAIL)
                    quiet = 1'b1;
                sender_gap();
                offer(pick_weight(style, i), i == size - 1, -1);
            end
        end
        s_tvalid <= 1'b0;

        // drain
        while (pending_codes.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);

        $display("sent %0d weights in %0d batches, %0d beyond capacity", items_sent, batches,
                 weights_dropped);
        $display("checked %0d code items, %0d mismatches", codes_checked, mismatches);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
